/* hdl/lmgc_pkg.sv */
`default_nettype none

package lmgc_pkg;

  localparam int TabDepth = 256;

  // The twelve bit output fraction is split into a table-driven head and a
  // tail that applies one root factor per pipeline stage.
  localparam int FracBits = 12;
  localparam int ExpSteps = 4;
  localparam int HeadBits = FracBits - ExpSteps;

  typedef logic [15:0] tab16_t [TabDepth];
  typedef logic [30:0] tab31_t [2**HeadBits];
  typedef logic [29:0] root_tab_t [13];

  // Word between the table lookup and the log scaling stages.
  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [15:0] expo;
    logic [15:0] mag;
  } lk_stage_t;

  // Word carried through the exp2 refinement stages.
  typedef struct packed {
    logic                valid;
    logic                zero;
    logic [5:0]          shift;
    logic [ExpSteps-1:0] low_bits;
    logic [30:0]         acc;
  } ex_stage_t;

  function automatic logic [63:0] isqrt64(logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bits;
    a    = a_in;
    res  = 64'd0;
    bits = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (a >= res + bits) begin
        a   = a - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Q30 roots 2^(-2^-i); each is the square root of the one before.
  function automatic root_tab_t make_roots();
    root_tab_t   r;
    logic [63:0] t;
    r[0] = 30'h2000_0000;
    for (int i = 1; i <= 12; i++) begin
      t    = 64'(r[i-1]) << 30;
      r[i] = 30'(isqrt64(t));
    end
    return r;
  endfunction

  localparam root_tab_t Roots = make_roots();

  // 2^(-frac / 2^nbits) in Q30, rounding after every factor.
  function automatic logic [63:0] pow2neg(logic [11:0] frac, int nbits);
    logic [63:0] acc;
    acc = 64'h4000_0000;
    for (int i = 1; i <= nbits; i++) begin
      if (((frac >> (nbits - i)) & 12'd1) != 12'd0) begin
        acc = (acc * 64'(Roots[i]) + 64'h2000_0000) >> 30;
      end
    end
    return acc;
  endfunction

  // log2 in Q.16 of an 8-bit integer by repeated squaring.
  function automatic logic [31:0] log2_q16(logic [7:0] x);
    int          n;
    logic [31:0] frac;
    logic [63:0] m;
    n    = 0;
    frac = 32'd0;
    for (int b = 1; b < 8; b++) begin
      if (x[b]) begin
        n = b;
      end
    end
    m = 64'(x) << (30 - n);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 32'd1;
        m    = m >> 1;
      end
    end
    return (32'(n) << 16) | frac;
  endfunction

  // Exponent in Q2.14 for each mask value.
  function automatic tab16_t build_exp_tab();
    tab16_t      t;
    logic [63:0] a;
    logic [63:0] e;
    for (int m = 0; m < TabDepth; m++) begin
      a    = pow2neg(12'(m % 128), 7);
      e    = (((a << 1) >> (m / 128)) + 64'h8000) >> 16;
      t[m] = 16'(e);
    end
    return t;
  endfunction

  // Magnitude of log2(value/255) in Q4.12 for each brightness.
  function automatic tab16_t build_log_tab();
    tab16_t      t;
    logic [31:0] lg_top;
    lg_top = log2_q16(8'd255);
    t[0]   = 16'd0;
    for (int v = 1; v < TabDepth; v++) begin
      t[v] = 16'((lg_top - log2_q16(8'(v)) + 32'd8) >> 4);
    end
    return t;
  endfunction

  // Leading factors of the output exp2, indexed by the top fraction bits.
  function automatic tab31_t build_exp_head_tab();
    tab31_t t;
    for (int f = 0; f < 2**HeadBits; f++) begin
      t[f] = 31'(pow2neg(12'(f), HeadBits));
    end
    return t;
  endfunction

  localparam tab16_t ExpTab     = build_exp_tab();
  localparam tab16_t LogTab     = build_log_tab();
  localparam tab31_t ExpHeadTab = build_exp_head_tab();

endpackage

`default_nettype wire

/* hdl/lmgc_lookup.sv */
`default_nettype none

module lmgc_lookup (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        pixel_value,
  input  wire logic [7:0]        local_mask,
  output lmgc_pkg::lk_stage_t    stage_out
);

  lmgc_pkg::lk_stage_t stage_r;
  lmgc_pkg::lk_stage_t stage_nxt;

  always_comb begin
    stage_nxt.valid = accept;
    stage_nxt.zero  = (pixel_value == 8'd0);
    stage_nxt.expo  = lmgc_pkg::ExpTab[local_mask];
    stage_nxt.mag   = lmgc_pkg::LogTab[pixel_value];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

/* hdl/lmgc_log_scale.sv */
`default_nettype none

module lmgc_log_scale (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lmgc_pkg::lk_stage_t stage_in,
  output lmgc_pkg::ex_stage_t    stage_out
);

  logic        valid2_r;
  logic        zero2_r;
  logic [31:0] prod_r;
  logic [31:0] prod_nxt;

  logic [31:0]         rounded;
  lmgc_pkg::ex_stage_t stage_r;
  lmgc_pkg::ex_stage_t stage_nxt;

  assign prod_nxt = 32'(stage_in.expo) * 32'(stage_in.mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid2_r <= 1'b0;
    end else begin
      valid2_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    zero2_r <= stage_in.zero;
    prod_r  <= prod_nxt;
  end

  // The product stays below 2^30, so the rounded sum cannot overflow.
  assign rounded = prod_r + 32'h0000_2000;

  always_comb begin
    stage_nxt.valid    = valid2_r;
    stage_nxt.zero     = zero2_r;
    stage_nxt.shift    = rounded[31:26];
    stage_nxt.low_bits = rounded[14 +: lmgc_pkg::ExpSteps];
    stage_nxt.acc      = lmgc_pkg::ExpHeadTab[rounded[25 -: lmgc_pkg::HeadBits]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

/* hdl/lmgc_exp2.sv */
`default_nettype none

module lmgc_exp2 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lmgc_pkg::ex_stage_t stage_in,
  output logic                   out_valid,
  output logic [7:0]             out_value
);

  lmgc_pkg::ex_stage_t stage_r   [lmgc_pkg::ExpSteps];
  lmgc_pkg::ex_stage_t stage_nxt [lmgc_pkg::ExpSteps];
  logic [60:0]         prod      [lmgc_pkg::ExpSteps];
  lmgc_pkg::ex_stage_t tail;

  logic        valid_r;
  logic [7:0]  value_r;
  logic [7:0]  value_nxt;
  logic [38:0] scaled;
  logic [38:0] shifted;
  logic [39:0] rounded;

  // One root factor per stage; fraction bits are taken from the top down.
  always_comb begin
    stage_nxt[0] = stage_in;
    for (int k = 1; k < lmgc_pkg::ExpSteps; k++) begin
      stage_nxt[k] = stage_r[k-1];
    end
    for (int k = 0; k < lmgc_pkg::ExpSteps; k++) begin
      prod[k] = 61'(stage_nxt[k].acc) * 61'(lmgc_pkg::Roots[lmgc_pkg::HeadBits+1+k])
                + 61'h2000_0000;
      if (stage_nxt[k].low_bits[lmgc_pkg::ExpSteps-1-k]) begin
        stage_nxt[k].acc = prod[k][60:30];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < lmgc_pkg::ExpSteps; k++) begin
        stage_r[k].valid <= 1'b0;
      end
    end else begin
      for (int k = 0; k < lmgc_pkg::ExpSteps; k++) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
  end

  assign tail = stage_r[lmgc_pkg::ExpSteps-1];

  always_comb begin
    scaled  = {tail.acc, 8'd0} - 39'(tail.acc);
    shifted = scaled >> tail.shift;
    rounded = 40'(shifted) + 40'h00_2000_0000;
    if (tail.zero) begin
      value_nxt = 8'd0;
    end else if (rounded[39:30] > 10'd255) begin
      value_nxt = 8'd255;
    end else begin
      value_nxt = rounded[37:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign out_valid = valid_r;
  assign out_value = value_r;

endmodule

`default_nettype wire

/* hdl/local_mask_gamma_correction.sv */
`default_nettype none
// Channel   Ports                                   Direction  Handshake
// input     in_pixel_value, in_local_mask           in         start high, busy low
// result    out_corrected_value                     out        out_valid, one cycle
//
// A word enters on every clock; busy is always low because nothing in the
// pipeline can stall. Each result is formed on the eight register stages
// described below once its word is accepted.
// Reset is synchronous and active low; it clears only the valid bits.
// The receiver cannot hold results off, so no result is ever held back.

module local_mask_gamma_correction (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_pixel_value,
  input  wire logic [7:0] in_local_mask,
  output logic            out_valid,
  output logic [7:0]      out_corrected_value
);

  // The exponent depends only on the mask and the log magnitude only on the
  // brightness, so both come from constant tables in the first stage. The
  // second stage forms their product, and the third rounds it into a shift
  // count and a twelve bit fraction. The top eight fraction bits select a
  // precomputed partial power of two; the four low bits each apply one more
  // Q30 root factor in a stage of their own. The last stage scales by 255,
  // applies the integer shift, rounds and saturates.

  lmgc_pkg::lk_stage_t lk_stage;
  lmgc_pkg::ex_stage_t ex_stage;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  lmgc_lookup u_lookup (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel_value (in_pixel_value),
    .local_mask  (in_local_mask),
    .stage_out   (lk_stage)
  );

  lmgc_log_scale u_log_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_in  (lk_stage),
    .stage_out (ex_stage)
  );

  lmgc_exp2 u_exp2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_in  (ex_stage),
    .out_valid (out_valid),
    .out_value (out_corrected_value)
  );

endmodule

`default_nettype wire

/* hdl/lmgc_checker.sv */
`default_nettype none

module lmgc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [7:0] in_pixel_value,
  input wire logic       out_valid,
  input wire logic [7:0] out_corrected_value
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised although the pipeline never stalls");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("accepted word produced no result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 8))
    else $error("result without an accepted word");

  a_dark_stays_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_pixel_value == 8'd0) |-> ##8 (out_corrected_value == 8'd0))
    else $error("zero brightness did not give zero");

  a_full_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_pixel_value == 8'd255) |-> ##8 (out_corrected_value == 8'd255))
    else $error("full brightness did not give full");

endmodule

bind local_mask_gamma_correction lmgc_checker u_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_pixel_value      (in_pixel_value),
  .out_valid           (out_valid),
  .out_corrected_value (out_corrected_value)
);

`default_nettype wire

/* bench/local_mask_gamma_correction_tb.sv */
`timescale 1ns / 1ps

module local_mask_gamma_correction_tb;

  localparam int PipeLatency = 8;
  localparam int MaxGap      = 4;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_pixel_value;
  logic [7:0] in_local_mask;
  logic       out_valid;
  logic [7:0] out_corrected_value;

  // One outstanding pixel: the inputs are kept so that a mismatch line can
  // say which pixel went wrong, not only what value was wrong.
  typedef struct {
    logic [7:0] pixel;
    logic [7:0] mask;
    logic [7:0] corrected;
  } pixel_expect_t;

  pixel_expect_t pending_pixels[$];
  int            mismatch_count;

  // Q30 square-root chain 2^(-2^-i); entry 0 is one half.
  logic [63:0] root_q30 [13];

  local_mask_gamma_correction u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_pixel_value     (in_pixel_value),
    .in_local_mask      (in_local_mask),
    .out_valid          (out_valid),
    .out_corrected_value(out_corrected_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous upper bound on run time. The 1125 words, each after its longest
  // idle gap, together with the drains, stay well below this.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Bit-serial integer square root, floor of sqrt(a_in).
  function automatic logic [63:0] int_sqrt(logic [63:0] a_in);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = a_in;
    root = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) begin
      bitv = bitv >> 2;
    end
    while (bitv != 64'd0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // 2^(-frac / 2^nbits) in Q30. Each set fraction bit multiplies in one
  // root, and the product is rounded back to Q30 after every factor.
  function automatic logic [63:0] neg_pow2_q30(logic [11:0] frac, int nbits);
    logic [63:0] acc;
    acc = 64'h4000_0000;
    for (int i = 1; i <= nbits; i++) begin
      if (frac[nbits - i]) begin
        acc = (acc * root_q30[i] + 64'h2000_0000) >> 30;
      end
    end
    return acc;
  endfunction

  // log2 of a nonzero 8-bit brightness in Q.16. The integer part is the
  // position of the top bit; the fraction comes from repeated squaring of
  // the Q30 mantissa, one bit per square, truncating as it goes.
  function automatic logic [31:0] brightness_log2(logic [7:0] x);
    int          top;
    logic [31:0] frac;
    logic [63:0] mant;
    top  = 0;
    frac = 32'd0;
    for (int b = 1; b < 8; b++) begin
      if (x[b]) begin
        top = b;
      end
    end
    mant = 64'(x) << (30 - top);
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= 64'h8000_0000) begin
        frac = frac | 32'd1;
        mant = mant >> 1;
      end
    end
    return (32'(top) << 16) | frac;
  endfunction

  // Corrected brightness 255 * (pixel/255)^e with e = 2^((128-mask)/128).
  function automatic logic [7:0] gamma_corrected(logic [7:0] pixel, logic [7:0] mask);
    logic [63:0] mask_pow;
    logic [63:0] expo_q14;
    logic [63:0] log_mag;
    logic [63:0] prod_mag;
    logic [63:0] frac_pow;
    logic [63:0] result;
    logic [63:0] whole;
    if (pixel == 8'd0) begin
      return 8'd0;
    end
    // Exponent in Q2.14. Masks of 128 and above halve 2 * 2^(-m/128).
    mask_pow = neg_pow2_q30({5'd0, mask[6:0]}, 7);
    expo_q14 = (((mask_pow << 1) >> mask[7]) + 64'h8000) >> 16;
    // Magnitude of log2(pixel/255) in Q4.12.
    log_mag  = 64'((brightness_log2(8'd255) - brightness_log2(pixel) + 32'd8) >> 4);
    prod_mag = (expo_q14 * log_mag + 64'h2000) >> 14;
    whole    = prod_mag >> 12;
    frac_pow = neg_pow2_q30(prod_mag[11:0], 12);
    if (whole >= 64'd40) begin
      result = 64'd0;
    end else begin
      result = (((64'd255 * frac_pow) >> whole) + 64'h2000_0000) >> 30;
    end
    if (result > 64'd255) begin
      result = 64'd255;
    end
    return result[7:0];
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Results cannot be held off, so every strobe is taken at the edge that
  // ends its cycle. Outputs are read before the edge's updates land.
  always @(posedge clk) begin : check_results
    pixel_expect_t head;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no word outstanding",
                                  out_corrected_value));
      end else begin
        head = pending_pixels.pop_front();
        if (out_corrected_value !== head.corrected) begin
          report_mismatch($sformatf("pixel %0d mask %0d: corrected %0d, predicted %0d",
                                    head.pixel, head.mask, out_corrected_value,
                                    head.corrected));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Sends one word after a random idle stretch bounded by max_gap. Start is
  // lowered only when a gap is taken, so a back-to-back word keeps start
  // high without a second assignment in the same time step. The expected
  // value is queued at the edge that accepts the word.
  task automatic send_pixel_word(input logic [7:0] pixel, input logic [7:0] mask,
                                 input int max_gap);
    int            gap;
    pixel_expect_t item;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          <= 1'b1;
    in_pixel_value <= pixel;
    in_local_mask  <= mask;
    do @(posedge clk); while (busy !== 1'b0);
    item.pixel     = pixel;
    item.mask      = mask;
    item.corrected = gamma_corrected(pixel, mask);
    pending_pixels.push_back(item);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PipeLatency) @(posedge clk);
  endtask

  // Corners of both fields: black, 254, white, the smallest nonzero pixel, and
  // the masks for the largest, unit and smallest exponents with 127 and 129.
  task automatic test_field_extremes();
    logic [7:0] pixels [4];
    logic [7:0] masks  [5];
    pixels = '{8'd0, 8'd1, 8'd254, 8'd255};
    masks  = '{8'd0, 8'd127, 8'd128, 8'd129, 8'd255};
    foreach (pixels[p]) begin
      foreach (masks[m]) begin
        send_pixel_word(pixels[p], masks[m], MaxGap);
      end
    end
  endtask

  // Mask 128 makes the exponent exactly one; rounding in the log and exp stages
  // may still move the output by one step. Two words with other masks follow.
  task automatic test_unit_exponent();
    send_pixel_word(8'd64, 8'd128, 0);
    send_pixel_word(8'd128, 8'd128, 0);
    send_pixel_word(8'd200, 8'd128, 0);
    send_pixel_word(8'hAA, 8'h55, 0);
    send_pixel_word(8'h55, 8'hAA, 0);
  endtask

  // Random pixels in stretches: some run at full rate, others with random
  // idle cycles. About one word in ten uses a corner value of a field.
  task automatic test_random_stream(input int count);
    int         gap_limit;
    logic [7:0] pixel;
    logic [7:0] mask;
    gap_limit = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        gap_limit = ($urandom_range(0, 2) == 0) ? 0 : MaxGap;
      end
      case ($urandom_range(0, 9))
        0: pixel = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
        1: pixel = 8'($urandom_range(1, 3));
        default: pixel = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0: mask = 8'd128;
        1: mask = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
        default: mask = 8'($urandom_range(0, 255));
      endcase
      send_pixel_word(pixel, mask, gap_limit);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_pixel_value = 8'd0;
    in_local_mask  = 8'd0;
    mismatch_count = 0;

    root_q30[0] = 64'h2000_0000;
    for (int i = 1; i <= 12; i++) begin
      root_q30[i] = int_sqrt(root_q30[i - 1] << 30);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_unit_exponent();
    test_random_stream(550);
    // The sender holds off here until the pipeline has emptied.
    drain_pipeline();
    test_random_stream(550);
    drain_pipeline();
    repeat (2 * PipeLatency) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
